@@ rtl/core/gmp_pkg.sv @@
`default_nettype none

package gmp_pkg;

  localparam int MAX_ROW_BLOCKS = 4;
  localparam int MAX_COL_BLOCKS = 4;
  localparam int MAX_LEN_WORDS  = 16;

  localparam int BLK      = 64;
  localparam int BLK_W    = $clog2(BLK);
  localparam int WORD_W   = 64;
  localparam int WIDX_W   = $clog2(MAX_LEN_WORDS);
  localparam int STORE_AW = BLK_W + WIDX_W;
  localparam int MAX_LEN  = BLK * MAX_LEN_WORDS;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_BLOCKS = 2'd0,
    CFG_COL_BLOCKS = 2'd1,
    CFG_POLY_LEN   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             load;
    logic [BLK_W-1:0] load_idx;
    logic             top_load;
    logic             shift;
  } tile_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/gf2_matpoly_to_polmat_convert_core.sv @@
// A source beat for a column other than the last of a 64-column block is only stored.
// A beat for the last column is followed by reading the 63 stored words
// of that coefficient word into the transpose tile through the registered store port,
// then one result per cycle (up to 64) while the result channel does not stall.
// Synchronous active-low reset clears the stream position and loads the register defaults;
// the bit-plane store is not cleared.
`default_nettype none

module gf2_matpoly_to_polmat_convert_core (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [gmp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [gmp_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire [63:0]                       in_src_word,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [63:0]                      out_row_word,
  output logic [9:0]                       out_coeff_index,
  output logic [1:0]                       out_row_block,
  output logic [1:0]                       out_col_block,
  output logic [5:0]                       out_row_in_block,
  output logic                             out_last_of_run,
  output logic                             out_matrix_done
);

  localparam int BW = gmp_pkg::BLK_W;
  localparam int WW = gmp_pkg::WIDX_W;

  gmp_pkg::state_t state_r, state_nxt;

  logic [2:0]  row_blocks_r, col_blocks_r;
  logic [10:0] poly_len_r;
  logic [7:0]  row_count_r, row_count_nxt;
  logic [7:0]  col_count_r, col_count_nxt;
  logic [WW-1:0] word_count_r, word_count_nxt;

  logic [2:0]  rb_eff, cb_eff;
  logic [10:0] len_eff;
  logic [11:0] len_sum;
  logic [4:0]  nwords;
  logic [8:0]  rows_m1, cols_m1;
  logic        word_wrap, col_wrap, row_wrap, last_input;
  logic [10:0] remain;

  logic [WW-1:0] w_r;
  logic [7:0]    row_r, col_r;
  logic          last_input_r;
  logic [BW-1:0] last_b_r, b_r;
  logic [BW-1:0] ld_cnt_r;
  logic          rd_pend_r;
  logic [BW-1:0] rd_idx_r;

  logic [gmp_pkg::WORD_W-1:0] store_mem [2**gmp_pkg::STORE_AW];
  logic [gmp_pkg::WORD_W-1:0] rd_data_r;
  logic                       rd_en;

  logic in_acc, out_acc, cfg_acc, is_top_col, emit_last;
  gmp_pkg::tile_ctl_t tile_ctl;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign in_acc    = in_valid & in_ready;
  assign out_acc   = out_valid & out_ready;

  always_comb begin
    if (row_blocks_r == 3'd0) begin
      rb_eff = 3'd1;
    end else if (row_blocks_r > 3'(gmp_pkg::MAX_ROW_BLOCKS)) begin
      rb_eff = 3'(gmp_pkg::MAX_ROW_BLOCKS);
    end else begin
      rb_eff = row_blocks_r;
    end
    if (col_blocks_r == 3'd0) begin
      cb_eff = 3'd1;
    end else if (col_blocks_r > 3'(gmp_pkg::MAX_COL_BLOCKS)) begin
      cb_eff = 3'(gmp_pkg::MAX_COL_BLOCKS);
    end else begin
      cb_eff = col_blocks_r;
    end
    if (poly_len_r == 11'd0) begin
      len_eff = 11'd1;
    end else if (poly_len_r > 11'(gmp_pkg::MAX_LEN)) begin
      len_eff = 11'(gmp_pkg::MAX_LEN);
    end else begin
      len_eff = poly_len_r;
    end
  end

  assign len_sum  = {1'b0, len_eff} + 12'd63;
  assign nwords   = len_sum[10:6];
  assign rows_m1  = {rb_eff, 6'd0} - 9'd1;
  assign cols_m1  = {cb_eff, 6'd0} - 9'd1;

  assign word_wrap  = {1'b0, word_count_r} == (nwords - 5'd1);
  assign col_wrap   = {1'b0, col_count_r} == cols_m1;
  assign row_wrap   = {1'b0, row_count_r} == rows_m1;
  assign last_input = word_wrap & col_wrap & row_wrap;
  assign is_top_col = col_count_r[BW-1:0] == BW'(gmp_pkg::BLK - 1);
  assign remain     = len_eff - {word_count_r, 6'd0};

  always_comb begin
    word_count_nxt = word_count_r;
    col_count_nxt  = col_count_r;
    row_count_nxt  = row_count_r;
    if (word_wrap) begin
      word_count_nxt = '0;
      if (col_wrap) begin
        col_count_nxt = '0;
        row_count_nxt = row_wrap ? 8'd0 : row_count_r + 8'd1;
      end else begin
        col_count_nxt = col_count_r + 8'd1;
      end
    end else begin
      word_count_nxt = word_count_r + WW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_blocks_r <= 3'd1;
      col_blocks_r <= 3'd1;
      poly_len_r   <= 11'd64;
      row_count_r  <= '0;
      col_count_r  <= '0;
      word_count_r <= '0;
    end else if (cfg_acc) begin
      case (cfg_index)
        gmp_pkg::CFG_ROW_BLOCKS: begin
          row_blocks_r <= cfg_data[2:0];
          row_count_r  <= '0;
          col_count_r  <= '0;
          word_count_r <= '0;
        end
        gmp_pkg::CFG_COL_BLOCKS: begin
          col_blocks_r <= cfg_data[2:0];
          row_count_r  <= '0;
          col_count_r  <= '0;
          word_count_r <= '0;
        end
        gmp_pkg::CFG_POLY_LEN: begin
          poly_len_r   <= cfg_data;
          row_count_r  <= '0;
          col_count_r  <= '0;
          word_count_r <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_acc) begin
      row_count_r  <= row_count_nxt;
      col_count_r  <= col_count_nxt;
      word_count_r <= word_count_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gmp_pkg::ST_IDLE: begin
        if (in_acc && is_top_col) begin
          state_nxt = gmp_pkg::ST_LOAD;
        end
      end
      gmp_pkg::ST_LOAD: begin
        if (ld_cnt_r == BW'(gmp_pkg::BLK - 1)) begin
          state_nxt = gmp_pkg::ST_EMIT;
        end
      end
      gmp_pkg::ST_EMIT: begin
        if (out_acc && emit_last) begin
          state_nxt = gmp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gmp_pkg::ST_IDLE;
    endcase
  end

  assign emit_last = b_r == last_b_r;

  always_comb begin
    in_ready          = 1'b0;
    out_valid         = 1'b0;
    rd_en             = 1'b0;
    tile_ctl.load     = rd_pend_r;
    tile_ctl.load_idx = rd_idx_r;
    tile_ctl.top_load = 1'b0;
    tile_ctl.shift    = 1'b0;
    case (state_r)
      gmp_pkg::ST_IDLE: begin
        in_ready          = 1'b1;
        tile_ctl.top_load = in_acc & is_top_col;
      end
      gmp_pkg::ST_LOAD: begin
        rd_en = ld_cnt_r != BW'(gmp_pkg::BLK - 1);
      end
      gmp_pkg::ST_EMIT: begin
        out_valid      = 1'b1;
        tile_ctl.shift = out_acc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= gmp_pkg::ST_IDLE;
      rd_pend_r <= 1'b0;
      ld_cnt_r  <= '0;
      b_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_en;
      if (in_acc) begin
        ld_cnt_r <= '0;
        b_r      <= '0;
      end else begin
        if (state_r == gmp_pkg::ST_LOAD) begin
          ld_cnt_r <= ld_cnt_r + BW'(1);
        end
        if (out_acc) begin
          b_r <= b_r + BW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      w_r          <= word_count_r;
      row_r        <= row_count_r;
      col_r        <= col_count_r;
      last_input_r <= last_input;
      last_b_r     <= (remain > 11'd64) ? BW'(gmp_pkg::BLK - 1) : BW'(remain - 11'd1);
    end
    rd_idx_r <= ld_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      store_mem[{col_count_r[BW-1:0], word_count_r}] <= in_src_word;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[{ld_cnt_r, w_r}];
    end
  end

  gmp_tile u_tile (
    .clk      (clk),
    .ctl      (tile_ctl),
    .rd_data  (rd_data_r),
    .top_word (in_src_word),
    .col_bits (out_row_word)
  );

  assign out_coeff_index  = 10'({w_r, b_r});
  assign out_row_block    = row_r[7:6];
  assign out_col_block    = col_r[7:6];
  assign out_row_in_block = row_r[5:0];
  assign out_last_of_run  = emit_last;
  assign out_matrix_done  = emit_last & last_input_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while results are pending");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !out_last_of_run) |=> out_valid)
    else $error("result run ended early");

  a_coeff_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !out_last_of_run) |=> out_coeff_index == $past(out_coeff_index) + 10'd1)
    else $error("coefficient index did not advance");

  a_read_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> state_r == gmp_pkg::ST_LOAD)
    else $error("store read landed outside tile load");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_matrix_done |-> out_last_of_run)
    else $error("matrix done without end of run");

endmodule

`default_nettype wire

@@ rtl/core/gmp_tile.sv @@
`default_nettype none

module gmp_tile (
  input  wire                         clk,
  input  gmp_pkg::tile_ctl_t          ctl,
  input  wire [gmp_pkg::WORD_W-1:0]   rd_data,
  input  wire [gmp_pkg::WORD_W-1:0]   top_word,
  output logic [gmp_pkg::BLK-1:0]     col_bits
);

  logic [gmp_pkg::WORD_W-1:0] tile_r [gmp_pkg::BLK];

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int i = 0; i < gmp_pkg::BLK; i++) begin
        tile_r[i] <= tile_r[i] >> 1;
      end
    end else begin
      if (ctl.load) begin
        tile_r[ctl.load_idx] <= rd_data;
      end
      if (ctl.top_load) begin
        tile_r[gmp_pkg::BLK-1] <= top_word;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < gmp_pkg::BLK; i++) begin
      col_bits[i] = tile_r[i][0];
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_gf2_matpoly_to_polmat_convert_core.sv @@
`default_nettype none

module tb_gf2_matpoly_to_polmat_convert_core;

  localparam logic [gmp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES  = 150;
  localparam int RX_HOLD        = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [63:0] row_word;
    logic [9:0]  coeff_index;
    logic [1:0]  row_block;
    logic [1:0]  col_block;
    logic [5:0]  row_in_block;
    logic        last_of_run;
    logic        matrix_done;
  } plane_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [gmp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gmp_pkg::CFG_DAT_W-1:0] cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [63:0]                   in_src_word = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [63:0]                   out_row_word;
  logic [9:0]                    out_coeff_index;
  logic [1:0]                    out_row_block;
  logic [1:0]                    out_col_block;
  logic [5:0]                    out_row_in_block;
  logic                          out_last_of_run;
  logic                          out_matrix_done;

  logic [63:0] src_words_q[$];
  plane_row_t  pending_rows[$];
  plane_row_t  want_row;

  logic [63:0] plane_mem [gmp_pkg::BLK][gmp_pkg::MAX_LEN_WORDS];
  int unsigned cur_row = 0;
  int unsigned cur_col = 0;
  int unsigned cur_word = 0;
  logic [2:0]  shadow_row_blocks = 3'd1;
  logic [2:0]  shadow_col_blocks = 3'd1;
  logic [10:0] shadow_poly_len = 11'd64;

  int mismatches = 0;
  int idle_cycles = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  bit calm = 1'b0;

  gf2_matpoly_to_polmat_convert_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_src_word      (in_src_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_row_word     (out_row_word),
    .out_coeff_index  (out_coeff_index),
    .out_row_block    (out_row_block),
    .out_col_block    (out_col_block),
    .out_row_in_block (out_row_in_block),
    .out_last_of_run  (out_last_of_run),
    .out_matrix_done  (out_matrix_done)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void transpose_src_word(logic [63:0] word);
    int unsigned rbe, cbe, lene, nw, cnt, w, c;
    logic        last_in;
    plane_row_t  r;
    rbe = (shadow_row_blocks == 0) ? 1 :
          ((shadow_row_blocks > gmp_pkg::MAX_ROW_BLOCKS) ? gmp_pkg::MAX_ROW_BLOCKS :
           shadow_row_blocks);
    cbe = (shadow_col_blocks == 0) ? 1 :
          ((shadow_col_blocks > gmp_pkg::MAX_COL_BLOCKS) ? gmp_pkg::MAX_COL_BLOCKS :
           shadow_col_blocks);
    lene = (shadow_poly_len == 0) ? 1 :
           ((shadow_poly_len > gmp_pkg::MAX_LEN) ? gmp_pkg::MAX_LEN : shadow_poly_len);
    nw = (lene + 63) / 64;
    if (cur_word >= nw || cur_col >= 64 * cbe || cur_row >= 64 * rbe) begin
      cur_row = 0;
      cur_col = 0;
      cur_word = 0;
    end
    w = cur_word;
    c = cur_col % 64;
    last_in = (cur_row == 64 * rbe - 1) && (cur_col == 64 * cbe - 1) && (w == nw - 1);
    plane_mem[c][w] = word;
    if (c == 63) begin
      cnt = lene - 64 * w;
      if (cnt > 64) cnt = 64;
      for (int b = 0; b < cnt; b++) begin
        for (int k = 0; k < 64; k++) r.row_word[k] = plane_mem[k][w][b];
        r.coeff_index  = 10'(64 * w + b);
        r.row_block    = 2'(cur_row >> 6);
        r.col_block    = 2'(cur_col >> 6);
        r.row_in_block = 6'(cur_row % 64);
        r.last_of_run  = (b == cnt - 1);
        r.matrix_done  = r.last_of_run && last_in;
        pending_rows.push_back(r);
      end
    end
    cur_word++;
    if (cur_word >= nw) begin
      cur_word = 0;
      cur_col++;
      if (cur_col >= 64 * cbe) begin
        cur_col = 0;
        cur_row++;
        if (cur_row >= 64 * rbe) cur_row = 0;
      end
    end
  endfunction

  function automatic logic [63:0] directed_word(int c);
    if (c == 0) return '1;
    if (c == 1) return '0;
    if (c == 63) return 64'hA5A5_5A5A_F00F_0FF0;
    return 64'h1 << c;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic push_random(int unsigned n);
    repeat (n) src_words_q.push_back({$urandom, $urandom});
  endtask

  task automatic settle();
    do @(negedge clk);
    while (src_words_q.size() != 0 || in_valid || pending_rows.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [gmp_pkg::CFG_IDX_W-1:0] idx,
                           logic [gmp_pkg::CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx != CFG_UNUSED) begin
      if (idx == gmp_pkg::CFG_ROW_BLOCKS) shadow_row_blocks = val[2:0];
      else if (idx == gmp_pkg::CFG_COL_BLOCKS) shadow_col_blocks = val[2:0];
      else shadow_poly_len = val;
      cur_row = 0;
      cur_col = 0;
      cur_word = 0;
    end
    @(posedge clk);
  endtask

  task automatic configure(logic [10:0] rb, logic [10:0] cb, logic [10:0] len);
    settle();
    write_reg(gmp_pkg::CFG_ROW_BLOCKS, rb);
    write_reg(gmp_pkg::CFG_COL_BLOCKS, cb);
    write_reg(gmp_pkg::CFG_POLY_LEN, len);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) transpose_src_word(in_src_word);
      if (!in_valid || in_ready) begin
        if (src_words_q.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
          in_valid    <= 1'b1;
          in_src_word <= src_words_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_rows.size() == 0) begin
          $error("result beat with no expectation, coeff_index %0d", out_coeff_index);
          mismatches++;
        end else begin
          want_row = pending_rows.pop_front();
          check_field("row_word", want_row.row_word, out_row_word);
          check_field("coeff_index", want_row.coeff_index, out_coeff_index);
          check_field("row_block", want_row.row_block, out_row_block);
          check_field("col_block", want_row.col_block, out_col_block);
          check_field("row_in_block", want_row.row_in_block, out_row_in_block);
          check_field("last_of_run", want_row.last_of_run, out_last_of_run);
          check_field("matrix_done", want_row.matrix_done, out_matrix_done);
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_left <= RX_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 24);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("gf2_matpoly_to_polmat_convert_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int c = 0; c < 20; c++) src_words_q.push_back(directed_word(c));
    settle();
    // A write to the unused index must leave the stream position alone.
    write_reg(CFG_UNUSED, 11'h7FF);
    for (int c = 20; c < 64; c++) src_words_q.push_back(directed_word(c));
    push_random(64);

    // The receiver holds off while the sender keeps offering beats.
    configure(11'd1, 11'd1, 11'd65);
    hold_req++;
    push_random(128);

    configure(11'd7, 11'h7FC, 11'd0);
    calm = 1'b1;
    push_random(128);
    settle();
    calm = 1'b0;

    settle();
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("gf2_matpoly_to_polmat_convert_core test passed");
    end else begin
      $display("gf2_matpoly_to_polmat_convert_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
